>>> hdl/cls_pkg.sv
// Package for the Cholesky linear solver: sizes, codes, sequencer states.
// No dependencies; used by every file in hdl.
package cls_pkg;
   localparam int MAX_ORDER = 8;
   localparam int IDX_W     = $clog2(MAX_ORDER);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int CNT_W     = IDX_W + 1;
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = DATA_W + FRAC_W;
   localparam int RAD_W     = NUM_W + (NUM_W % 2);
   localparam int STEP_W    = $clog2(RAD_W + 1);
   localparam int ACC_W     = 64;

   localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
   localparam logic [1:0] CMD_SOLVE       = 2'd2;

   localparam logic REG_SIZE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BASE, ST_BASE2, ST_CHK, ST_RDA, ST_RDB, ST_MUL, ST_ACC,
      ST_FIN, ST_PIV, ST_DIV, ST_SQRT, ST_WR, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {PH_FACT, PH_FWD, PH_BACK} phase_type;

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
      lo = -hi - ACC_W'(64'sd1);
      if (v > hi) return hi[DATA_W-1:0];
      else if (v < lo) return lo[DATA_W-1:0];
      else return v[DATA_W-1:0];
   endfunction
endpackage

>>> hdl/cholesky_linear_solver_unit.sv
// Operation: a load request is taken only while idle. A solve takes about n^3/6 + n^2
// multiply-accumulate steps (check, two reads, multiply, accumulate), plus for every
// entry of L, y and x a setup and write-back and either a square root (diagonal of L)
// or a pivot fetch and divide, then emits x, each entry held while rsp_stall is high.
// Throughput: loads one per cycle while idle; one solve at a time, requests stalled.
// Reset: synchronous, clears control state and sets the order to 8; stores undefined.
module cholesky_linear_solver_unit import cls_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [2:0]               req_row_index,
   input  logic [2:0]               req_column_index,
   input  logic signed [31:0]       req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_solution_value,
   output logic [2:0]               rsp_solution_index,
   output logic                     rsp_last_flag,
   output logic                     rsp_status,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   logic signed [DATA_W-1:0] matrix_mem [MAX_ORDER*MAX_ORDER];
   logic signed [DATA_W-1:0] factor_mem [MAX_ORDER*MAX_ORDER];
   logic signed [DATA_W-1:0] rhs_ff [MAX_ORDER];
   logic signed [DATA_W-1:0] y_ff   [MAX_ORDER];
   logic signed [DATA_W-1:0] x_ff   [MAX_ORDER];

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [3:0] size_ff;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, e_ff, e_in;
   logic [CNT_W-1:0] k_ff, k_in, kend_ff, kend_in;
   logic fail_ff, fail_in, sq_ff, sq_in, neg_ff, neg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, prod_ff, prod_in;
   logic signed [DATA_W-1:0] opa_ff, opa_in, mat_rd_ff, fac_rd_ff, vec_rd_ff, vec_sel;
   logic [ADDR_W-1:0] fac_raddr;
   logic [RAD_W-1:0] rad_ff, rad_in, res_ff, res_in, bit_ff, bit_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0] rem_ff, rem_in, rem_t;
   logic [DATA_W-1:0] piv_ff, piv_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_val_ff, rsp_val_in, wr_val;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0] n_ord;
   logic [IDX_W-1:0] nm1;
   logic signed [ACC_W-1:0] rounded;
   logic signed [DATA_W-1:0] dsat;
   logic [NUM_W-1:0] mag;
   logic [ACC_W-1:0] qext;
   logic csr_wr, wr_fac, wr_y, wr_x;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SIZE) ? {28'd0, size_ff} : 32'd0;

   always_comb begin
      if (size_ff == 4'd0) n_ord = CNT_W'(1);
      else if (size_ff > 4'(MAX_ORDER)) n_ord = CNT_W'(MAX_ORDER);
      else n_ord = CNT_W'(size_ff);
   end
   assign nm1 = IDX_W'(n_ord - CNT_W'(1));

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_value = rsp_val_ff;
   assign rsp_solution_index = rsp_idx_ff;
   assign rsp_last_flag      = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

   assign rounded = (prod_ff + (ACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
   assign dsat    = sat_data(acc_ff);
   assign rem_t   = {rem_ff[DATA_W-1:0], quo_ff[NUM_W-1]};

   always_comb begin
      qext = ACC_W'(quo_ff);
      if (sq_ff) wr_val = sat_data($signed(ACC_W'(res_ff)));
      else if (piv_ff == '0) wr_val = '0;
      else if (neg_ff) wr_val = sat_data(-$signed(qext));
      else wr_val = sat_data($signed(qext));
   end

   always_comb begin
      fac_raddr = {i_ff, k_ff[IDX_W-1:0]};
      vec_sel   = rhs_ff[i_ff];
      case (state_ff)
         ST_RDA: begin
            fac_raddr = (phase_ff == PH_BACK) ? {k_ff[IDX_W-1:0], i_ff} : {i_ff, k_ff[IDX_W-1:0]};
            vec_sel   = (phase_ff == PH_BACK) ? x_ff[k_ff[IDX_W-1:0]] : y_ff[k_ff[IDX_W-1:0]];
         end
         ST_RDB: begin
            fac_raddr = {j_ff, k_ff[IDX_W-1:0]};
            vec_sel   = vec_rd_ff;
         end
         ST_FIN:  fac_raddr = (phase_ff == PH_FACT) ? {j_ff, j_ff} : {i_ff, i_ff};
         default: vec_sel = (phase_ff == PH_BACK) ? y_ff[i_ff] : rhs_ff[i_ff];
      endcase
   end

   always_comb begin
      state_in = state_ff; phase_in = phase_ff;
      i_in = i_ff; j_in = j_ff; e_in = e_ff; k_in = k_ff; kend_in = kend_ff;
      fail_in = fail_ff; sq_in = sq_ff; neg_in = neg_ff;
      acc_in = acc_ff; prod_in = prod_ff; opa_in = opa_ff;
      rad_in = rad_ff; res_in = res_ff; bit_in = bit_ff;
      quo_in = quo_ff; rem_in = rem_ff; piv_in = piv_ff; cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_val_in = rsp_val_ff; rsp_idx_in = rsp_idx_ff;
      rsp_last_in = rsp_last_ff; rsp_status_in = rsp_status_ff;
      wr_fac = 1'b0; wr_y = 1'b0; wr_x = 1'b0;
      mag = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_command == CMD_SOLVE) begin
               phase_in = PH_FACT; i_in = '0; j_in = '0; fail_in = 1'b0;
               state_in = ST_BASE;
            end
         end
         ST_BASE: state_in = ST_BASE2;
         ST_BASE2: begin
            acc_in = (phase_ff == PH_FACT) ? ACC_W'(mat_rd_ff) : ACC_W'(vec_rd_ff);
            case (phase_ff)
               PH_FACT: begin k_in = '0; kend_in = CNT_W'(j_ff); end
               PH_FWD:  begin k_in = '0; kend_in = CNT_W'(i_ff); end
               default: begin k_in = CNT_W'(i_ff) + CNT_W'(1); kend_in = n_ord; end
            endcase
            state_in = ST_CHK;
         end
         ST_CHK: state_in = (k_ff < kend_ff) ? ST_RDA : ST_FIN;
         ST_RDA: state_in = ST_RDB;
         ST_RDB: begin opa_in = fac_rd_ff; state_in = ST_MUL; end
         ST_MUL: begin
            prod_in  = opa_ff * ((phase_ff == PH_FACT) ? fac_rd_ff : vec_rd_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff - rounded; k_in = k_ff + CNT_W'(1); state_in = ST_CHK;
         end
         ST_FIN: begin
            cnt_in = '0;
            if (phase_ff == PH_FACT && i_ff == j_ff) begin
               sq_in = 1'b1;
               if (dsat <= 0) begin
                  fail_in = 1'b1; e_in = '0; state_in = ST_EMIT;
               end else begin
                  rad_in = RAD_W'({dsat, {FRAC_W{1'b0}}});
                  res_in = '0;
                  bit_in = RAD_W'(1) << (RAD_W - 2);
                  state_in = ST_SQRT;
               end
            end else begin
               sq_in  = 1'b0;
               neg_in = dsat[DATA_W-1];
               mag    = NUM_W'({dsat, {FRAC_W{1'b0}}});
               quo_in = neg_in ? -mag : mag;
               rem_in = '0;
               state_in = ST_PIV;
            end
         end
         ST_PIV: begin piv_in = fac_rd_ff; state_in = ST_DIV; end
         ST_DIV: begin
            if (rem_t >= {1'b0, piv_ff}) begin
               rem_in = rem_t - {1'b0, piv_ff}; quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_t; quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(NUM_W - 1)) state_in = ST_WR;
         end
         ST_SQRT: begin
            if (rad_ff >= res_ff + bit_ff) begin
               rad_in = rad_ff - (res_ff + bit_ff); res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(RAD_W / 2 - 1)) state_in = ST_WR;
         end
         ST_WR: begin
            state_in = ST_BASE;
            case (phase_ff)
               PH_FACT: begin
                  wr_fac = 1'b1;
                  if (j_ff != i_ff) j_in = j_ff + IDX_W'(1);
                  else if (i_ff == nm1) begin phase_in = PH_FWD; i_in = '0; end
                  else begin i_in = i_ff + IDX_W'(1); j_in = '0; end
               end
               PH_FWD: begin
                  wr_y = 1'b1;
                  if (i_ff == nm1) phase_in = PH_BACK;
                  else i_in = i_ff + IDX_W'(1);
               end
               default: begin
                  wr_x = 1'b1;
                  if (i_ff == '0) begin e_in = '0; state_in = ST_EMIT; end
                  else i_in = i_ff - IDX_W'(1);
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_val_in    = fail_ff ? '0 : x_ff[e_ff];
               rsp_idx_in    = e_ff;
               rsp_last_in   = (e_ff == nm1);
               rsp_status_in = fail_ff;
               e_in = e_ff + IDX_W'(1);
               if (e_ff == nm1) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= 4'(MAX_ORDER);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && csr_paddr[2] == REG_SIZE) size_ff <= csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in; i_ff <= i_in; j_ff <= j_in; e_ff <= e_in;
      k_ff <= k_in; kend_ff <= kend_in; fail_ff <= fail_in; sq_ff <= sq_in;
      neg_ff <= neg_in; acc_ff <= acc_in; prod_ff <= prod_in; opa_ff <= opa_in;
      rad_ff <= rad_in; res_ff <= res_in; bit_ff <= bit_in; quo_ff <= quo_in;
      rem_ff <= rem_in; piv_ff <= piv_in; cnt_ff <= cnt_in;
      rsp_val_ff <= rsp_val_in; rsp_idx_ff <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in; rsp_status_ff <= rsp_status_in;
      vec_rd_ff <= vec_sel;
      if (wr_y) y_ff[i_ff] <= wr_val;
      if (wr_x) x_ff[i_ff] <= wr_val;
      if (state_ff == ST_IDLE && req_valid && req_command == CMD_LOAD_RHS)
         rhs_ff[req_row_index] <= req_element_value;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_command == CMD_LOAD_MATRIX)
         matrix_mem[{req_row_index, req_column_index}] <= req_element_value;
      mat_rd_ff <= matrix_mem[{i_ff, j_ff}];
   end

   always_ff @(posedge clock) begin
      if (wr_fac) factor_mem[{i_ff, j_ff}] <= wr_val;
      fac_rd_ff <= factor_mem[fac_raddr];
   end
endmodule

>>> hdl/cls_checker.sv
// Port-level checker for the Cholesky linear solver, bound to the top level.
// Depends on cls_pkg and cholesky_linear_solver_unit.
module cls_checker import cls_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_command,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [31:0] rsp_solution_value,
   input logic              rsp_last_flag,
   input logic              rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solution_value))
      else $error("stalled response changed");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_solution_value == 0)
      else $error("failed solve with nonzero value");
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_SOLVE |=> req_stall)
      else $error("solve request not held off");
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_flag |-> req_stall)
      else $error("request taken during result run");
endmodule

bind cholesky_linear_solver_unit cls_checker u_cls_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_solution_value(rsp_solution_value), .rsp_last_flag(rsp_last_flag),
   .rsp_status(rsp_status)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for cholesky_linear_solver_unit: loads matrices and right-hand vectors,
// solves them, and checks each solution element against an in-bench fixed-point solver.
// Depends on cls_pkg and the RTL top level only.
module tb;
   import cls_pkg::*;

   typedef struct {
      logic [1:0]         command;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
   } request_type;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         index;
      logic               last;
      logic               status;
   } solution_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SPD_COUNT   = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic [2:0] req_row_index = '0;
   logic [2:0] req_column_index = '0;
   logic signed [31:0] req_element_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_solution_value;
   logic [2:0] rsp_solution_index;
   logic rsp_last_flag;
   logic rsp_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   cholesky_linear_solver_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   request_type  pending_requests[$];
   solution_type expected_solutions[$];
   int errors = 0;
   int cycles = 0;
   int solves_sent = 0;
   int solutions_seen = 0;
   int pd_failures = 0;
   int sizes_seen[9];
   bit req_taken = 1'b0;

   logic [3:0]         order_reg = 4'd8;
   logic signed [31:0] mat_a[64];
   logic signed [31:0] vec_b[8];
   logic signed [31:0] fac_l[64];
   logic signed [31:0] vec_y[8];
   logic signed [31:0] vec_x[8];

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd32768;
      return p >>> FRAC_W;
   endfunction

   function automatic logic signed [31:0] qdiv(input logic signed [63:0] num,
                                               input logic signed [31:0] pivot);
      logic signed [63:0] d;
      if (pivot == 0) return 0;
      d = 64'(clamp32(num)) * 64'sd65536;
      return clamp32(d / 64'(pivot));
   endfunction

   function automatic logic signed [31:0] qroot(input logic signed [31:0] d);
      logic [63:0] rad, res, bitv;
      rad = 64'(d) << FRAC_W;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rad) bitv >>= 2;
      while (bitv != 0) begin
         if (rad >= res + bitv) begin
            rad -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return clamp32($signed(res));
   endfunction

   task automatic solve_system(output bit ok, input int n);
      logic signed [63:0] acc;
      logic signed [31:0] d;
      ok = 1'b1;
      for (int i = 0; i < n && ok; i++)
         for (int j = 0; j <= i && ok; j++) begin
            acc = 0;
            for (int k = 0; k < j; k++) acc += qmul(fac_l[i*8+k], fac_l[j*8+k]);
            if (i == j) begin
               d = clamp32(64'(mat_a[i*8+j]) - acc);
               if (d <= 0) ok = 1'b0;
               else fac_l[i*8+i] = qroot(d);
            end else begin
               fac_l[i*8+j] = qdiv(64'(mat_a[i*8+j]) - acc, fac_l[j*8+j]);
            end
         end
      if (!ok) return;
      for (int i = 0; i < n; i++) begin
         acc = 0;
         for (int j = 0; j < i; j++) acc += qmul(fac_l[i*8+j], vec_y[j]);
         vec_y[i] = qdiv(64'(vec_b[i]) - acc, fac_l[i*8+i]);
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = 0;
         for (int j = i + 1; j < n; j++) acc += qmul(fac_l[j*8+i], vec_x[j]);
         vec_x[i] = qdiv(64'(vec_y[i]) - acc, fac_l[i*8+i]);
      end
   endtask

   task automatic predict_request(input request_type r);
      int n;
      bit ok;
      solution_type s;
      case (r.command)
         CMD_LOAD_MATRIX: mat_a[r.row*8+r.col] = r.value;
         CMD_LOAD_RHS:    vec_b[r.row] = r.value;
         CMD_SOLVE: begin
            n = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
            solve_system(ok, n);
            sizes_seen[n]++;
            if (!ok) pd_failures++;
            for (int i = 0; i < n; i++) begin
               s.value = ok ? vec_x[i] : 32'sd0;
               s.index = 3'(i);
               s.last = (i == n - 1);
               s.status = !ok;
               expected_solutions.push_back(s);
            end
         end
         default: ;
      endcase
   endtask

   // Driver: bursts with random gaps
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            void'(pending_requests.pop_front());
            if (req_command == CMD_SOLVE) solves_sent++;
         end
         if (req_valid && !req_taken) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_valid <= 1'b1;
            req_command <= pending_requests[0].command;
            req_row_index <= pending_requests[0].row;
            req_column_index <= pending_requests[0].col;
            req_element_value <= pending_requests[0].value;
            if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted solutions
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         predict_request('{req_command, req_row_index, req_column_index, req_element_value});
      if (!reset && rsp_valid && !rsp_stall) begin
         solutions_seen++;
         if (expected_solutions.size() == 0) begin
            $error("solution with none expected: value %0d index %0d",
                   rsp_solution_value, rsp_solution_index);
            errors++;
         end else begin
            solution_type e;
            e = expected_solutions.pop_front();
            if (rsp_solution_value !== e.value) begin
               $error("solution_value expected %0d actual %0d", e.value, rsp_solution_value);
               errors++;
            end
            if (rsp_solution_index !== e.index) begin
               $error("solution_index expected %0d actual %0d", e.index, rsp_solution_index);
               errors++;
            end
            if (rsp_last_flag !== e.last) begin
               $error("last_flag expected %0d actual %0d", e.last, rsp_last_flag);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver stall pattern, plus one long hold-off after the eighth solve
   int stall_phase = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 23;
      if (!hold_done && solves_sent == 8) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      if (hold_left > 0) rsp_stall <= 1'b1;
      else if (stall_phase < 8) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   task automatic write_order(input logic [3:0] n);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * REG_SIZE);
      csr_pwdata <= 32'(n);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      order_reg = n;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic request_type make_req(input logic [1:0] c, input int r, input int k,
                                            input logic signed [31:0] v);
      request_type q;
      q.command = c;
      q.row = 3'(r);
      q.col = 3'(k);
      q.value = v;
      return q;
   endfunction

   // Diagonally dominant SPD system, or random entries when wild; lower triangle only
   task automatic queue_spd_system(input int n, input bit wild);
      logic signed [31:0] off;
      int span;
      span = wild ? 32'h7fff_ffff : 32'h0002_0000;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < i; j++) begin
            off = $signed($urandom_range(0, 2 * span)) - span;
            if (wild) off = $urandom;
            pending_requests.push_back(make_req(CMD_LOAD_MATRIX, i, j, off));
         end
      for (int i = 0; i < n; i++)
         pending_requests.push_back(make_req(CMD_LOAD_MATRIX, i, i,
            wild ? $signed($urandom) : $signed(32'h0001_0000 * (2 * n + 1)
                                                + $urandom_range(0, 32'h000f_ffff))));
      for (int i = 0; i < n; i++)
         pending_requests.push_back(make_req(CMD_LOAD_RHS, i, $urandom_range(0, 7),
            ($urandom_range(0, 5) == 0) ? $signed($urandom)
                                        : $signed($urandom_range(0, 32'h0010_0000)) - 32'sh8_0000));
      if ($urandom_range(0, 4) == 0)
         pending_requests.push_back(make_req(2'd3, $urandom_range(0, 7),
                                             $urandom_range(0, 7), $urandom));
      pending_requests.push_back(make_req(CMD_SOLVE, $urandom_range(0, 7),
                                          $urandom_range(0, 7), $urandom));
   endtask

   task automatic drain(input int tail);
      while (pending_requests.size() > 0 || req_valid || expected_solutions.size() > 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   int n_sel;
   initial begin
      foreach (mat_a[i]) begin
         mat_a[i] = 0;
         fac_l[i] = 0;
      end
      for (int i = 0; i < 8; i++) begin
         vec_b[i] = 0;
         vec_y[i] = 0;
         vec_x[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: order 1, extremes
      write_order(4'd1);
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 32'sh7fffffff));
      pending_requests.push_back(make_req(CMD_LOAD_RHS, 0, 7, 32'sh80000000));
      pending_requests.push_back(make_req(CMD_SOLVE, 7, 7, 32'sh7fffffff));
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 32'sh0000_0001));
      pending_requests.push_back(make_req(CMD_LOAD_RHS, 0, 0, 32'sh7fffffff));
      pending_requests.push_back(make_req(CMD_SOLVE, 0, 0, 0));
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 32'sh80000000));
      pending_requests.push_back(make_req(CMD_SOLVE, 0, 0, 0));
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 0));
      pending_requests.push_back(make_req(2'd3, 7, 7, 32'sh7fffffff));
      pending_requests.push_back(make_req(CMD_SOLVE, 0, 0, 0));
      drain(4000);
      // order 0 acts as 1
      write_order(4'd0);
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 32'sh0004_0000));
      pending_requests.push_back(make_req(CMD_SOLVE, 0, 0, 0));
      drain(4000);
      // order 2, indefinite, then above range acting as 8
      write_order(4'd2);
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 1, 0, 32'sh0002_0000));
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 1, 1, 32'sh0001_0000));
      pending_requests.push_back(make_req(CMD_LOAD_MATRIX, 0, 0, 32'sh0001_0000));
      pending_requests.push_back(make_req(CMD_LOAD_RHS, 1, 0, 32'sh0001_0000));
      pending_requests.push_back(make_req(CMD_LOAD_RHS, 0, 0, 32'sh0001_0000));
      pending_requests.push_back(make_req(CMD_SOLVE, 0, 0, 0));
      drain(4000);
      write_order(4'd15);
      queue_spd_system(8, 1'b0);
      drain(4000);

      // random phases; the receiver holds back once while a burst of systems goes in
      while (pending_requests.size() == 0 && solves_sent < 18) begin
         n_sel = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 4);
         write_order(4'(n_sel));
         for (int s = 0; s < 3; s++) queue_spd_system(n_sel, $urandom_range(0, 9) == 0);
         drain(4000);
      end

      $display("solves: %0d, solutions checked: %0d, not-positive-definite: %0d",
               solves_sent, solutions_seen, pd_failures);
      $display("orders exercised: 1:%0d 2:%0d 3:%0d 4:%0d 8:%0d", sizes_seen[1],
               sizes_seen[2], sizes_seen[3], sizes_seen[4], sizes_seen[8]);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> cholesky_linear_solver_unit.f
hdl/cls_pkg.sv
hdl/cholesky_linear_solver_unit.sv
hdl/cls_checker.sv
tb/tb.sv
